// ----- design/pwgw_pkg.sv -----
// ----------------------------------------------------------------------------
// pwgw_pkg: shared types for the piecewise linear gain warp
// Request and result payloads, configuration set, control codes.
// ----------------------------------------------------------------------------
package pwgw_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int IDX_BITS    = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SAT   = 2'd1,
		ST_EARLY = 2'd2
	} status_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_CONTROL_COUNT = 3'd0,
		REG_GAIN_LOW      = 3'd1,
		REG_GAIN_HIGH     = 3'd2,
		REG_AXIS_START    = 3'd3,
		REG_AXIS_END      = 3'd4
	} reg_idx_t;

	// kind of work handed to the back end
	typedef enum logic [1:0] {
		K_LOAD   = 2'd0,
		K_SAMPLE = 2'd1,
		K_EARLY  = 2'd2
	} kind_t;

	// where the position falls relative to the axis range
	typedef enum logic [1:0] {
		CL_NONE  = 2'd0,
		CL_FIRST = 2'd1,
		CL_LAST  = 2'd2
	} clamp_t;

	typedef struct packed {
		kind_t  kind;
		clamp_t clamp;
		logic   last;
	} ctl_t;

	typedef struct packed {
		logic                          cmd;
		logic [23:0]                   draw;
		logic signed [SAMPLE_BITS-1:0] sample_value;
		logic [31:0]                   sample_position;
		logic                          last_in_row;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] warped_value;
		logic                          row_end;
		logic [1:0]                    status;
	} out_item_t;

	typedef struct packed {
		logic [4:0]         control_count;
		logic signed [23:0] gain_low;
		logic signed [23:0] gain_high;
		logic [31:0]        axis_start;
		logic [31:0]        axis_end;
	} cfg_t;

endpackage

// ----- design/piecewise_linear_gain_warp.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_gain_warp: spectrum row gain warp
// Scales samples by a gain curve interpolated between per-row control gains.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on push/full; each row starts with control_count load
//    requests (cmd 0) carrying draws, then sample requests (cmd 1).
//  - Results leave on empty/pop, one per sample request, in order; loads give
//    none. A sample before all gains are loaded gives 0 with status 2.
//  - Throughput: one request per cycle while full is low and results are popped.
//    Each sample passes the work queue, the segment divider (one bit per
//    stage), the 25-stage interpolation divider and the table, multiply,
//    round and result registers.
//  - full rises when the 4-entry work queue fills; a stalled result (pop low)
//    freezes the whole back pipeline while the queue keeps taking requests.
//  - Reset clears the loaded-gain count, queue and pipeline; registers return
//    to defaults. The gain table has no reset.
//  - Write registers only while idle.
module piecewise_linear_gain_warp #(
	parameter int MAX_CONTROL = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  pwgw_pkg::in_item_t                     item,
	output logic                                   empty,
	input  logic                                   pop,
	output pwgw_pkg::out_item_t                    result,
	input  logic                                   wr_en,
	input  logic [pwgw_pkg::IDX_BITS-1:0]          wr_index,
	input  logic [31:0]                            wr_data
);
	import pwgw_pkg::*;

	localparam int QB = $clog2(MAX_CONTROL);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_count <= 5'd2;
			cfg_q.gain_low      <= 24'sd1048576;
			cfg_q.gain_high     <= 24'sd1048576;
			cfg_q.axis_start    <= 32'd0;
			cfg_q.axis_end      <= 32'd16711680;
		end else if (wr_en) begin
			case (wr_index)
				REG_CONTROL_COUNT: cfg_q.control_count <= wr_data[4:0];
				REG_GAIN_LOW:      cfg_q.gain_low      <= wr_data[23:0];
				REG_GAIN_HIGH:     cfg_q.gain_high     <= wr_data[23:0];
				REG_AXIS_START:    cfg_q.axis_start    <= wr_data;
				REG_AXIS_END:      cfg_q.axis_end      <= wr_data;
				default: ;
			endcase
		end
	end

	// only used for interior positions, where axis_end > axis_start
	logic [31:0] span;
	assign span = cfg_q.axis_end - cfg_q.axis_start;

	logic                   enq;
	ctl_t                   e_ctl;
	logic signed [SAMPLE_BITS-1:0] e_value;
	logic signed [23:0]     e_gw;
	logic [QB-1:0]          e_widx;
	logic [QB-1:0]          e_top;
	logic [32+QB-1:0]       e_t;

	pwgw_front #(.MAX_CONTROL(MAX_CONTROL)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.cfg     (cfg_q),
		.q_full  (full),
		.enq     (enq),
		.e_ctl   (e_ctl),
		.e_value (e_value),
		.e_gw    (e_gw),
		.e_widx  (e_widx),
		.e_top   (e_top),
		.e_t     (e_t)
	);

	pwgw_back #(.MAX_CONTROL(MAX_CONTROL)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.e_ctl   (e_ctl),
		.e_value (e_value),
		.e_gw    (e_gw),
		.e_widx  (e_widx),
		.e_top   (e_top),
		.e_t     (e_t),
		.span    (span),
		.pop     (pop),
		.q_full  (full),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ----- design/pwgw_front.sv -----
// ----------------------------------------------------------------------------
// pwgw_front: request intake and classification
// Tracks gains loaded per row, builds load gains, positions samples.
// ----------------------------------------------------------------------------
module pwgw_front #(
	parameter int MAX_CONTROL = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  pwgw_pkg::in_item_t                     item,
	input  pwgw_pkg::cfg_t                         cfg,
	input  logic                                   q_full,
	output logic                                   enq,
	output pwgw_pkg::ctl_t                         e_ctl,
	output logic signed [pwgw_pkg::SAMPLE_BITS-1:0] e_value,
	output logic signed [23:0]                     e_gw,
	output logic [$clog2(MAX_CONTROL)-1:0]         e_widx,
	output logic [$clog2(MAX_CONTROL)-1:0]         e_top,
	output logic [32+$clog2(MAX_CONTROL)-1:0]      e_t
);
	import pwgw_pkg::*;

	localparam int QB = $clog2(MAX_CONTROL);
	localparam int LW = $clog2(MAX_CONTROL + 1);
	localparam int TW = 32 + QB;

	logic [LW-1:0]      loaded_q;
	logic [6:0]         k7;
	logic [LW-1:0]      kk;
	logic               take;
	logic               is_load;
	logic               can_load;
	logic signed [24:0] gdiff;
	logic signed [48:0] gprod;
	logic [31:0]        off;
	logic [36:0]        tprod;

	always_comb begin
		k7 = {2'b00, cfg.control_count};
		if (k7 < 7'd2) begin
			k7 = 7'd2;
		end else if (k7 > 7'(MAX_CONTROL)) begin
			k7 = 7'(MAX_CONTROL);
		end
	end
	assign kk = LW'(k7);

	assign take     = push && !q_full;
	assign is_load  = (item.cmd == CMD_LOAD);
	assign can_load = (loaded_q < kk);
	assign enq      = take && (!is_load || can_load);

	// control gain = lo + floor((hi - lo) * draw / 2^24)
	assign gdiff = 25'(cfg.gain_high) - 25'(cfg.gain_low);
	assign gprod = gdiff * $signed({1'b0, item.draw});
	assign e_gw  = cfg.gain_low + $signed(gprod[47:24]);

	assign e_widx = QB'(loaded_q);
	assign e_top  = QB'(kk - LW'(1));

	assign off   = item.sample_position - cfg.axis_start;
	assign tprod = 37'(off) * 37'(kk - LW'(1));
	assign e_t   = TW'(tprod);

	assign e_value = item.sample_value;

	always_comb begin
		e_ctl.last = item.last_in_row;
		if (is_load) begin
			e_ctl.kind = K_LOAD;
		end else if (!can_load) begin
			e_ctl.kind = K_SAMPLE;
		end else begin
			e_ctl.kind = K_EARLY;
		end
		if (item.sample_position <= cfg.axis_start) begin
			e_ctl.clamp = CL_FIRST;
		end else if (item.sample_position >= cfg.axis_end) begin
			e_ctl.clamp = CL_LAST;
		end else begin
			e_ctl.clamp = CL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (take) begin
			if (is_load) begin
				if (can_load) begin
					loaded_q <= loaded_q + LW'(1);
				end
			end else if (item.last_in_row) begin
				loaded_q <= '0;
			end
		end
	end

endmodule

// ----- design/pwgw_back.sv -----
// ----------------------------------------------------------------------------
// pwgw_back: work queue and gain pipeline
// Segment divide, gain table, interpolation divide, multiply, saturate.
// ----------------------------------------------------------------------------
module pwgw_back #(
	parameter int MAX_CONTROL = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   enq,
	input  pwgw_pkg::ctl_t                         e_ctl,
	input  logic signed [pwgw_pkg::SAMPLE_BITS-1:0] e_value,
	input  logic signed [23:0]                     e_gw,
	input  logic [$clog2(MAX_CONTROL)-1:0]         e_widx,
	input  logic [$clog2(MAX_CONTROL)-1:0]         e_top,
	input  logic [32+$clog2(MAX_CONTROL)-1:0]      e_t,
	input  logic [31:0]                            span,
	input  logic                                   pop,
	output logic                                   q_full,
	output logic                                   empty,
	output pwgw_pkg::out_item_t                    result
);
	import pwgw_pkg::*;

	localparam int QB = $clog2(MAX_CONTROL);
	localparam int TW = 32 + QB;
	localparam int SB = SAMPLE_BITS;
	localparam int NQ = 25;
	localparam int PW = 57;
	localparam int L  = SB / 2;
	localparam int HW = SB - L;
	localparam int SW = SB + 25;
	localparam int PTRW = $clog2(QUEUE_DEPTH);
	localparam logic signed [SB+4:0] SMAX = $signed({6'b0, {(SB-1){1'b1}}});
	localparam logic signed [SB+4:0] SMIN = $signed({{6{1'b1}}, {(SB-1){1'b0}}});

	typedef struct packed {
		ctl_t               ctl;
		logic signed [SB-1:0] value;
		logic signed [23:0] gw;
		logic [QB-1:0]      widx;
		logic [QB-1:0]      top;
		logic [TW-1:0]      rem;
		logic [QB-1:0]      q;
	} dst_t;

	typedef struct packed {
		ctl_t               ctl;
		logic signed [SB-1:0] value;
		logic signed [23:0] g0;
		logic               neg;
		logic [PW-1:0]      rem;
		logic [NQ-1:0]      q;
	} qst_t;

	logic adv;

	// work queue
	dst_t            fifo_q [QUEUE_DEPTH];
	logic [PTRW-1:0] wp_q;
	logic [PTRW-1:0] rp_q;
	logic [PTRW:0]   cnt_q;
	logic            nonempty;
	logic            deq;
	dst_t            head;

	assign q_full   = (cnt_q == (PTRW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign deq      = adv && nonempty;
	assign head     = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wp_q] <= '{ctl: e_ctl, value: e_value, gw: e_gw, widx: e_widx,
				top: e_top, rem: e_t, q: '0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wp_q <= wp_q + PTRW'(1);
			end
			if (deq) begin
				rp_q <= rp_q + PTRW'(1);
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + (PTRW+1)'(1);
			end else if (!enq && deq) begin
				cnt_q <= cnt_q - (PTRW+1)'(1);
			end
		end
	end

	// segment divide: one quotient bit per stage
	dst_t div_s  [1:QB];
	logic dvld_s [1:QB];
	dst_t div_src [0:QB-1];
	logic dvld_src [0:QB-1];

	genvar j;
	generate
		for (j = 0; j < QB; j++) begin : g_seg
			localparam int B = QB - 1 - j;
			logic [TW-1:0] dsh;
			dst_t          nxt;
			if (j == 0) begin : g_head
				assign div_src[j]  = head;
				assign dvld_src[j] = nonempty;
			end else begin : g_prev
				assign div_src[j]  = div_s[j];
				assign dvld_src[j] = dvld_s[j];
			end
			assign dsh = TW'(span) << B;
			always_comb begin
				nxt = div_src[j];
				if (div_src[j].ctl.clamp == CL_NONE && div_src[j].rem >= dsh) begin
					nxt.rem  = div_src[j].rem - dsh;
					nxt.q[B] = 1'b1;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					div_s[j+1] <= nxt;
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dvld_s[j+1] <= 1'b0;
				end else if (adv) begin
					dvld_s[j+1] <= dvld_src[j];
				end
			end
		end
	endgenerate

	// gain table: loads write, samples read both segment ends
	logic signed [23:0] gmem [MAX_CONTROL];
	dst_t               dd;
	logic [QB-1:0]      idx0;
	logic [QB-1:0]      idx1;
	logic [31:0]        rem32;

	assign dd = div_s[QB];

	always_comb begin
		case (dd.ctl.clamp)
			CL_FIRST: idx0 = '0;
			CL_LAST:  idx0 = dd.top;
			default:  idx0 = dd.q;
		endcase
		idx1  = (dd.ctl.clamp == CL_NONE) ? idx0 + QB'(1) : idx0;
		rem32 = (dd.ctl.clamp == CL_NONE) ? dd.rem[31:0] : 32'd0;
	end

	ctl_t               ctl_s1;
	logic signed [SB-1:0] value_s1;
	logic [31:0]        rem_s1;
	logic signed [23:0] g0_s1;
	logic signed [23:0] g1_s1;
	logic               vld_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dvld_s[QB] && dd.ctl.kind == K_LOAD) begin
				gmem[dd.widx] <= dd.gw;
			end
			g0_s1    <= gmem[idx0];
			g1_s1    <= gmem[idx1];
			ctl_s1   <= dd.ctl;
			value_s1 <= dd.value;
			rem_s1   <= rem32;
		end
	end

	// |g1 - g0| * remainder
	logic signed [24:0] gd;
	logic [24:0]        gmag;
	ctl_t               ctl_s2;
	logic signed [SB-1:0] value_s2;
	logic signed [23:0] g0_s2;
	logic               neg_s2;
	logic [PW-1:0]      prod_s2;
	logic               vld_s2;

	assign gd   = 25'(g1_s1) - 25'(g0_s1);
	assign gmag = gd[24] ? 25'(-gd) : 25'(gd);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2   <= ctl_s1;
			value_s2 <= value_s1;
			g0_s2    <= g0_s1;
			neg_s2   <= gd[24];
			prod_s2  <= PW'(gmag) * PW'(rem_s1);
		end
	end

	// interpolation divide by span
	qst_t qt_s   [1:NQ];
	logic qvld_s [1:NQ];
	qst_t qt_src [0:NQ-1];
	logic qvld_src [0:NQ-1];

	generate
		for (j = 0; j < NQ; j++) begin : g_int
			localparam int B = NQ - 1 - j;
			logic [PW-1:0] dsh;
			qst_t          nxt;
			if (j == 0) begin : g_first
				assign qt_src[j] = '{ctl: ctl_s2, value: value_s2, g0: g0_s2,
					neg: neg_s2, rem: prod_s2, q: '0};
				assign qvld_src[j] = vld_s2;
			end else begin : g_prev
				assign qt_src[j]   = qt_s[j];
				assign qvld_src[j] = qvld_s[j];
			end
			assign dsh = PW'(span) << B;
			always_comb begin
				nxt = qt_src[j];
				if (qt_src[j].ctl.clamp == CL_NONE && qt_src[j].rem >= dsh) begin
					nxt.rem  = qt_src[j].rem - dsh;
					nxt.q[B] = 1'b1;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					qt_s[j+1] <= nxt;
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					qvld_s[j+1] <= 1'b0;
				end else if (adv) begin
					qvld_s[j+1] <= qvld_src[j];
				end
			end
		end
	endgenerate

	// floor quotient, add to first gain
	qst_t               qe;
	logic [NQ:0]        qmag;
	logic [NQ:0]        qsgn;
	ctl_t               ctl_s3;
	logic signed [SB-1:0] value_s3;
	logic signed [23:0] gain_s3;
	logic               vld_s3;

	assign qe   = qt_s[NQ];
	assign qmag = {1'b0, qe.q} + (NQ+1)'(qe.rem != '0);
	assign qsgn = qe.neg ? -qmag : {1'b0, qe.q};

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3   <= qe.ctl;
			value_s3 <= qe.value;
			gain_s3  <= qe.g0 + $signed(qsgn[23:0]);
		end
	end

	// split multiply
	ctl_t                 ctl_s4;
	logic signed [L+24:0] plo_s4;
	logic signed [HW+23:0] phi_s4;
	logic                 vld_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			plo_s4 <= $signed({1'b0, value_s3[L-1:0]}) * gain_s3;
			phi_s4 <= $signed(value_s3[SB-1:L]) * gain_s3;
		end
	end

	// round half up, drop 20 fraction bits
	logic signed [SW-1:0] psum;
	ctl_t                 ctl_s5;
	logic signed [SB+4:0] sh_s5;
	logic                 vld_s5;

	assign psum = (SW'(phi_s4) <<< L) + SW'(plo_s4) + SW'(20'h80000);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5 <= ctl_s4;
			sh_s5  <= psum[SW-1:20];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= dvld_s[QB];
			vld_s2 <= vld_s1;
			vld_s3 <= qvld_s[NQ];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// saturate into the result register
	logic      out_v_q;
	out_item_t res_d;

	always_comb begin
		res_d.row_end = ctl_s5.last;
		if (ctl_s5.kind == K_EARLY) begin
			res_d.warped_value = '0;
			res_d.status       = ST_EARLY;
		end else if (sh_s5 > SMAX) begin
			res_d.warped_value = SMAX[SB-1:0];
			res_d.status       = ST_SAT;
		end else if (sh_s5 < SMIN) begin
			res_d.warped_value = SMIN[SB-1:0];
			res_d.status       = ST_SAT;
		end else begin
			res_d.warped_value = sh_s5[SB-1:0];
			res_d.status       = ST_OK;
		end
	end

	assign adv   = !out_v_q || pop;
	assign empty = !out_v_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vld_s5 && (ctl_s5.kind != K_LOAD);
		end
	end

endmodule
